### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bmpu_pkg.sv
// ----------------------------------------------------------------------------
// BMP pixel unpacker package
// Shared widths, register indexes and the types passed between modules.
// ----------------------------------------------------------------------------
package bmpu_pkg;

    localparam int DIM_BITS       = 12;
    localparam int COLOR_BITS     = 24;
    localparam int OUT_BITS       = 13;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X          = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y          = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRANSPARENT_COLOR = 3'd4;

    localparam logic [COLOR_BITS-1:0] COLOR_KEY_RESET = 24'hFF00FF;

    typedef enum logic [1:0] {
        PHASE_BLUE,
        PHASE_GREEN,
        PHASE_RED
    } phase_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]   image_width;
        logic [DIM_BITS-1:0]   image_height;
        logic [DIM_BITS-1:0]   origin_x;
        logic [DIM_BITS-1:0]   origin_y;
        logic [COLOR_BITS-1:0] transparent_color;
    } cfg_t;

    typedef struct packed {
        logic [OUT_BITS-1:0]   x;
        logic [OUT_BITS-1:0]   y;
        logic [COLOR_BITS-1:0] color;
    } pixel_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] pad;
    } status_t;

endpackage

### design/bmpu_core.sv
// ----------------------------------------------------------------------------
// BMP pixel unpacker core
// Byte assembly, row padding and the column and row counters for one word.
// ----------------------------------------------------------------------------
module bmpu_core #(
    parameter int COORD_BITS = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       data_byte,
    input  bmpu_pkg::cfg_t   cfg,
    output logic             emit,
    output bmpu_pkg::pixel_t pixel,
    output bmpu_pkg::status_t status
);
    import bmpu_pkg::*;

    localparam int SUM_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;

    phase_t                phase_reg, phase_next;
    logic [15:0]           partial_reg, partial_next;
    logic [COORD_BITS-1:0] column_reg, column_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [1:0]            pad_reg, pad_next;

    logic [DIM_BITS-1:0]   width_eff;
    logic [DIM_BITS-1:0]   height_eff;
    logic [SUM_BITS-1:0]   column_inc;
    logic [SUM_BITS-1:0]   row_inc;
    logic [SUM_BITS-1:0]   x_sum;
    logic [OUT_BITS-1:0]   row_out;
    logic [COLOR_BITS-1:0] color;

    always_comb
    begin
        width_eff  = (cfg.image_width == '0) ? DIM_BITS'(1) : cfg.image_width;
        height_eff = (cfg.image_height == '0) ? DIM_BITS'(1) : cfg.image_height;
        column_inc = SUM_BITS'(column_reg) + SUM_BITS'(1);
        row_inc    = SUM_BITS'(row_reg) + SUM_BITS'(1);
        x_sum      = SUM_BITS'(cfg.origin_x) + SUM_BITS'(column_reg);
        row_out    = OUT_BITS'(SUM_BITS'(row_reg));
        color      = {data_byte, partial_reg};
    end

    always_comb
    begin
        pixel.x     = x_sum[OUT_BITS-1:0];
        pixel.y     = OUT_BITS'(cfg.origin_y) + OUT_BITS'(height_eff) - OUT_BITS'(1) - row_out;
        pixel.color = color;
        emit        = advance && (pad_reg == 2'd0) && (phase_reg == PHASE_RED)
                      && (color != cfg.transparent_color);
        status.phase = phase_reg;
        status.pad   = pad_reg;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        column_next  = column_reg;
        row_next     = row_reg;
        pad_next     = pad_reg;
        if (advance)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 2'd1;
            end
            else
            begin
                case (phase_reg)
                    PHASE_BLUE:
                    begin
                        partial_next = {8'd0, data_byte};
                        phase_next   = PHASE_GREEN;
                    end
                    PHASE_GREEN:
                    begin
                        partial_next = {data_byte, partial_reg[7:0]};
                        phase_next   = PHASE_RED;
                    end
                    PHASE_RED:
                    begin
                        partial_next = '0;
                        phase_next   = PHASE_BLUE;
                        if (column_inc >= SUM_BITS'(width_eff))
                        begin
                            column_next = '0;
                            pad_next    = width_eff[1:0];
                            if (row_inc >= SUM_BITS'(height_eff))
                            begin
                                row_next = '0;
                            end
                            else
                            begin
                                row_next = row_inc[COORD_BITS-1:0];
                            end
                        end
                        else
                        begin
                            column_next = column_inc[COORD_BITS-1:0];
                        end
                    end
                    default:
                    begin
                        phase_next = PHASE_BLUE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PHASE_BLUE;
            partial_reg <= '0;
            column_reg  <= '0;
            row_reg     <= '0;
            pad_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            column_reg  <= column_next;
            row_reg     <= row_next;
            pad_reg     <= pad_next;
        end
    end

endmodule

### design/bmp24_pixel_unpacker.sv
// ----------------------------------------------------------------------------
// BMP 24-bit pixel unpacker
// Turns the bottom-up pixel area of a 24-bit BMP into screen-space pixels.
// ----------------------------------------------------------------------------
// One byte word is taken per cycle at a sustained rate of one per clock while
// the result register is not held; a byte goes from the input register through
// the assembly and counter logic into the result register, and a held result
// stalls the input register. The register update for all counters and the
// color-key compare happen in the single step between those two registers.
// Register writes take effect at once and are meant to be made while no words
// are in flight.
`include "assert_macros.svh"

module bmp24_pixel_unpacker #(
    parameter int COORD_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [7:0]                             data_byte,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [bmpu_pkg::OUT_BITS-1:0]          pixel_x,
    output logic [bmpu_pkg::OUT_BITS-1:0]          pixel_y,
    output logic [bmpu_pkg::COLOR_BITS-1:0]        pixel_color,
    input  logic                                   cfg_en,
    input  logic [bmpu_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [bmpu_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import bmpu_pkg::*;

    localparam int MASK_BITS = (COORD_BITS < DIM_BITS) ? COORD_BITS : DIM_BITS;
    localparam logic [DIM_BITS-1:0] DimMask = DIM_BITS'((32'd1 << MASK_BITS) - 32'd1);

    cfg_t             cfg_reg, cfg_next;
    logic             in_valid_reg, in_valid_next;
    logic [7:0]       byte_reg;
    logic             out_valid_reg, out_valid_next;
    pixel_t           pixel_reg;
    logic             out_free;
    logic             advance;
    logic             emit;
    pixel_t           pixel;
    status_t          status;
    logic [DIM_BITS-1:0] dim_data;

    bmpu_core #(
        .COORD_BITS(COORD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (byte_reg),
        .cfg       (cfg_reg),
        .emit      (emit),
        .pixel     (pixel),
        .status    (status)
    );

    always_comb
    begin
        dim_data = cfg_data[DIM_BITS-1:0] & DimMask;
        cfg_next = cfg_reg;
        if (cfg_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:       cfg_next.image_width       = dim_data;
                REG_IMAGE_HEIGHT:      cfg_next.image_height      = dim_data;
                REG_ORIGIN_X:          cfg_next.origin_x          = dim_data;
                REG_ORIGIN_Y:          cfg_next.origin_y          = dim_data;
                REG_TRANSPARENT_COLOR: cfg_next.transparent_color = cfg_data[COLOR_BITS-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        advance  = in_valid_reg && out_free;
        in_stall = in_valid_reg && !out_free;

        if (in_valid && !in_stall)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (out_free)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        out_valid   = out_valid_reg;
        pixel_x     = pixel_reg.x;
        pixel_y     = pixel_reg.y;
        pixel_color = pixel_reg.color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width       <= DIM_BITS'(1);
            cfg_reg.image_height      <= DIM_BITS'(1);
            cfg_reg.origin_x          <= '0;
            cfg_reg.origin_y          <= '0;
            cfg_reg.transparent_color <= COLOR_KEY_RESET;
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
        end
        if (emit)
        begin
            pixel_reg <= pixel;
        end
    end

    `ASSERT_SAME(a_pad_only_between_pixels, status.pad != 2'd0, status.phase == PHASE_BLUE,
        "pad bytes pending in the middle of a pixel")
    `ASSERT_NEXT(a_held_word_kept, in_valid_reg && !out_free, in_valid_reg,
        "buffered input word dropped while the result register was full")
    `ASSERT_SAME(a_result_from_advance, $rose(out_valid_reg), $past(advance),
        "result appeared without a word being processed")
    `ASSERT_NEXT(a_emit_loads_result, emit, out_valid_reg,
        "drawn pixel not presented on the result register")

endmodule

### tb/sv/tb_bmp24_pixel_unpacker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP 24-bit pixel unpacker testbench
// Streams bottom-up pixel-area bytes into the unpacker under several image
// settings and checks every drawn pixel against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_bmp24_pixel_unpacker;
    import bmpu_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_BYTES  = 400;

    typedef struct packed {
        phase_t              phase;
        logic [15:0]         partial;
        logic [DIM_BITS-1:0] col;
        logic [DIM_BITS-1:0] row;
        logic [1:0]          pad;
    } unpack_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] data_byte = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [OUT_BITS-1:0] pixel_x;
    logic [OUT_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic cfg_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    logic [DIM_BITS-1:0]   cfg_width = 12'd1;
    logic [DIM_BITS-1:0]   cfg_height = 12'd1;
    logic [DIM_BITS-1:0]   cfg_origin_x = '0;
    logic [DIM_BITS-1:0]   cfg_origin_y = '0;
    logic [COLOR_BITS-1:0] cfg_key = COLOR_KEY_RESET;

    unpack_state_t live_state = '0;
    pixel_t        predicted;
    pixel_t        pixel_expect[$];
    logic [7:0]    byte_queue[$];

    int  errors = 0;
    int  cycle_count = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_grants = 0;
    int  hold_seen = 0;

    bmp24_pixel_unpacker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .cfg_en      (cfg_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Advances the unpacker state by one byte; returns 1 when a pixel is drawn.
    function automatic bit unpack_byte(inout unpack_state_t st, input logic [7:0] b,
                                       output pixel_t pix);
        logic [DIM_BITS-1:0]   w;
        logic [DIM_BITS-1:0]   h;
        logic [COLOR_BITS-1:0] color;
        pix = '0;
        w = (cfg_width == '0) ? 12'd1 : cfg_width;
        h = (cfg_height == '0) ? 12'd1 : cfg_height;
        if (st.pad != 2'd0) begin
            st.pad = st.pad - 2'd1;
            return 1'b0;
        end
        if (st.phase == PHASE_BLUE) begin
            st.partial = {8'h00, b};
            st.phase = PHASE_GREEN;
            return 1'b0;
        end
        if (st.phase == PHASE_GREEN) begin
            st.partial[15:8] = b;
            st.phase = PHASE_RED;
            return 1'b0;
        end
        color = {b, st.partial};
        pix.x = 13'(cfg_origin_x) + 13'(st.col);
        pix.y = 13'(cfg_origin_y) + 13'(h) - 13'd1 - 13'(st.row);
        pix.color = color;
        st.phase = PHASE_BLUE;
        st.partial = '0;
        if ({1'b0, st.col} + 13'd1 >= {1'b0, w}) begin
            st.col = '0;
            st.pad = w[1:0];
            if ({1'b0, st.row} + 13'd1 >= {1'b0, h})
                st.row = '0;
            else
                st.row = st.row + 12'd1;
        end
        else begin
            st.col = st.col + 12'd1;
        end
        return color != cfg_key;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 1;
        if (r < 90)
            return $urandom_range(2, 4);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [DIM_BITS-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 12'd1;
            2: return 12'd4095;
            3: return DIM_BITS'($urandom_range(1, 4095));
            default: return DIM_BITS'($urandom_range(1, 9));
        endcase
    endfunction

    function automatic logic [DIM_BITS-1:0] pick_origin();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 12'd4095;
            default: return DIM_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_en <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:       cfg_width = val[DIM_BITS-1:0];
            REG_IMAGE_HEIGHT:      cfg_height = val[DIM_BITS-1:0];
            REG_ORIGIN_X:          cfg_origin_x = val[DIM_BITS-1:0];
            REG_ORIGIN_Y:          cfg_origin_y = val[DIM_BITS-1:0];
            REG_TRANSPARENT_COLOR: cfg_key = val[COLOR_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic write_image(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h,
                               input logic [DIM_BITS-1:0] ox, input logic [DIM_BITS-1:0] oy,
                               input logic [COLOR_BITS-1:0] key);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
        write_reg(REG_ORIGIN_X, CFG_DATA_BITS'(ox));
        write_reg(REG_ORIGIN_Y, CFG_DATA_BITS'(oy));
        write_reg(REG_TRANSPARENT_COLOR, key);
    endtask

    task automatic push_pixel(input logic [COLOR_BITS-1:0] color);
        byte_queue.push_back(color[7:0]);
        byte_queue.push_back(color[15:8]);
        byte_queue.push_back(color[23:16]);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (!(byte_queue.size() == 0 && !in_valid && pixel_expect.size() == 0));
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Byte source.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            data_byte <= '0;
            gap_left = 0;
        end
        else if (!(in_valid && in_stall)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (byte_queue.size() > 0) begin
                data_byte <= byte_queue.pop_front();
                in_valid <= 1'b1;
                gap_left = (gaps_on && $urandom_range(0, 99) < 35) ? pick_len() : 0;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Pixel sink.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (hold_seen != hold_grants) begin
                hold_seen++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 99) < 25) begin
                stall_left = pick_len() - 1;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Prediction on accepted bytes and comparison on accepted pixels.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                if (unpack_byte(live_state, data_byte, predicted))
                    pixel_expect.push_back(predicted);
            end
            if (out_valid && !out_stall) begin
                if (pixel_expect.size() == 0) begin
                    $display("%0t: unexpected pixel x=%0d y=%0d color=%06h", $time,
                             pixel_x, pixel_y, pixel_color);
                    errors++;
                end
                else begin
                    predicted = pixel_expect.pop_front();
                    if (pixel_x !== predicted.x) begin
                        $display("%0t: pixel_x expected %0d, actual %0d", $time,
                                 predicted.x, pixel_x);
                        errors++;
                    end
                    if (pixel_y !== predicted.y) begin
                        $display("%0t: pixel_y expected %0d, actual %0d", $time,
                                 predicted.y, pixel_y);
                        errors++;
                    end
                    if (pixel_color !== predicted.color) begin
                        $display("%0t: pixel_color expected %06h, actual %06h", $time,
                                 predicted.color, pixel_color);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        unpack_state_t         plan;
        pixel_t                scratch;
        logic [COLOR_BITS-1:0] color;
        logic [7:0]            b;
        int                    random_total;
        int                    phase_no;
        int                    target;
        int                    n;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one-pixel rows with one pad byte each, default key.
        push_pixel(24'h000000);
        byte_queue.push_back(8'hAA);
        push_pixel(COLOR_KEY_RESET);
        byte_queue.push_back(8'h55);
        push_pixel(24'hFFFFFF);
        byte_queue.push_back(8'h00);
        wait_idle();

        // Writes to unused indexes must change nothing; zero sizes act as one.
        for (int i = int'(REG_TRANSPARENT_COLOR) + 1; i < (1 << CFG_INDEX_BITS); i++)
            write_reg(CFG_INDEX_BITS'(i), CFG_DATA_BITS'($urandom()));
        write_image('0, '0, 12'd4095, 12'd4095, 24'h000000);
        push_pixel(24'h000000);
        byte_queue.push_back(8'hFF);
        push_pixel(24'h123456);
        byte_queue.push_back(8'h81);
        wait_idle();

        random_total = 0;
        phase_no = 0;
        while (random_total < RANDOM_BYTES) begin
            // The first phases shrink the image under counters that are already
            // past the new limits, in both the column and the row direction.
            case (phase_no)
                0: write_image(12'd4095, 12'd4095, pick_origin(), pick_origin(),
                               24'($urandom()));
                1: write_image(12'd3, 12'd1, pick_origin(), pick_origin(), 24'($urandom()));
                2: write_image(12'd1, 12'd4095, pick_origin(), pick_origin(),
                               24'($urandom()));
                3: write_image(12'd5, 12'd2, pick_origin(), pick_origin(), 24'($urandom()));
                default: write_image(pick_dim(), pick_dim(), pick_origin(), pick_origin(),
                                     ($urandom_range(0, 4) == 0) ?
                                     (($urandom_range(0, 1) == 0) ? 24'hFFFFFF : 24'h000000)
                                     : 24'($urandom()));
            endcase
            gaps_on = (phase_no % 4 != 2);
            stalls_on = (phase_no % 4 != 2);
            target = $urandom_range(20, 60);
            if (phase_no == 5) begin
                gaps_on = 1'b0;
                target = 90;
                hold_grants++;
            end

            plan = live_state;
            n = 0;
            while (n < target) begin
                if (plan.pad != 2'd0 || plan.phase != PHASE_BLUE
                        || $urandom_range(0, 19) == 0) begin
                    b = 8'($urandom_range(0, 255));
                    byte_queue.push_back(b);
                    void'(unpack_byte(plan, b, scratch));
                    n++;
                end
                else begin
                    color = ($urandom_range(0, 3) == 0) ? cfg_key : 24'($urandom());
                    for (int k = 0; k < 3; k++) begin
                        b = color[8*k +: 8];
                        byte_queue.push_back(b);
                        void'(unpack_byte(plan, b, scratch));
                        n++;
                    end
                end
            end
            random_total += n;
            phase_no++;
            wait_idle();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### bmp24_pixel_unpacker.f
+incdir+design
design/bmpu_pkg.sv
design/bmpu_core.sv
design/bmp24_pixel_unpacker.sv
tb/sv/tb_bmp24_pixel_unpacker.sv
